// ===== rtl/tns_pkg.sv =====
// shared types and constants of the tone note sequencer
package tns_pkg;

	// default note table depth
	localparam int unsigned MAX_NOTES_DEF = 64;

	// field widths
	localparam int unsigned FUNC_W = 2;
	localparam int unsigned SLOT_W = 6;
	localparam int unsigned FREQ_W = 15;
	localparam int unsigned DUR_W  = 16;
	localparam int unsigned TICK_W = 13;
	localparam int unsigned DIVR_W = 16;
	localparam int unsigned POS_W  = 7;
	localparam int unsigned LEN_W  = 7;

	// timer input clock, the dividend of every tone divisor
	localparam int unsigned CLOCK_W = 21;
	localparam logic [CLOCK_W-1:0] CLOCK_HZ = 21'd1193180;

	// duration in ms to 10 ms ticks: (d * 52429) >> 19 is exact for 16-bit d
	localparam int unsigned RECIP_W = 17;
	localparam logic [RECIP_W-1:0] DIV10_MUL = 17'd52429;
	localparam int unsigned DIV10_SHIFT = 19;

	// item function codes
	typedef enum logic [FUNC_W-1:0] {
		FUNC_LOAD  = 2'd0,
		FUNC_START = 2'd1,
		FUNC_TICK  = 2'd2
	} func_t;

	// sequencer states
	typedef enum logic [2:0] {
		ST_IDLE,
		ST_READ,
		ST_DIV,
		ST_DONE
	} state_t;

endpackage

// ===== rtl/tns_note_mem.sv =====
// note table memory: frequency and duration per slot, one write and one registered read port
module tns_note_mem #(
	parameter int unsigned DEPTH  = tns_pkg::MAX_NOTES_DEF,
	parameter int unsigned AW     = 6,
	parameter int unsigned DATA_W = tns_pkg::FREQ_W + tns_pkg::DUR_W
) (
	input  logic              clk,
	input  logic              we,
	input  logic [AW-1:0]     waddr,
	input  logic [DATA_W-1:0] wdata,
	input  logic              re,
	input  logic [AW-1:0]     raddr,
	output logic [DATA_W-1:0] rdata
);

	logic [DATA_W-1:0] mem [DEPTH];
	logic [DATA_W-1:0] rdata_q;

	// write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// read port, registered
	always_ff @(posedge clk) begin
		if (re) begin
			rdata_q <= mem[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

// ===== rtl/tns_div.sv =====
// bit-serial divider: timer clock divided by note frequency, one quotient bit a cycle
module tns_div (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        start,
	input  logic [tns_pkg::FREQ_W-1:0]  divisor,
	output logic                        done,
	output logic [tns_pkg::DIVR_W-1:0]  quotient
);

	localparam int unsigned CW = $clog2(tns_pkg::CLOCK_W);
	localparam logic [CW-1:0] LAST = CW'(tns_pkg::CLOCK_W - 1);

	logic                         run_q;
	logic                         done_q;
	logic [CW-1:0]                cnt_q;
	logic [tns_pkg::FREQ_W-1:0]   rem_q;
	logic [tns_pkg::FREQ_W-1:0]   dvs_q;
	logic [tns_pkg::CLOCK_W-1:0]  dq_q;

	logic [tns_pkg::FREQ_W:0]     trial;
	logic                         fits;
	logic [tns_pkg::FREQ_W:0]     diff;
	logic [tns_pkg::FREQ_W-1:0]   rem_nxt;

	// one restoring step: bring down the next dividend bit and try to subtract
	always_comb begin
		trial   = {rem_q, dq_q[tns_pkg::CLOCK_W-1]};
		fits    = (trial >= {1'b0, dvs_q});
		diff    = trial - {1'b0, dvs_q};
		rem_nxt = fits ? diff[tns_pkg::FREQ_W-1:0] : trial[tns_pkg::FREQ_W-1:0];
	end

	// control: run flag, step counter, done pulse
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q  <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				run_q <= 1'b1;
				cnt_q <= '0;
			end else if (run_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == LAST) begin
					run_q  <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// datapath: dividend bits shift out while quotient bits shift in
	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			dvs_q <= divisor;
			dq_q  <= tns_pkg::CLOCK_HZ;
		end else if (run_q) begin
			rem_q <= rem_nxt;
			dq_q  <= {dq_q[tns_pkg::CLOCK_W-2:0], fits};
		end
	end

	assign done     = done_q;
	assign quotient = dq_q[tns_pkg::DIVR_W-1:0];

endmodule

// ===== rtl/tone_note_sequencer_unit.sv =====
// Tone note sequencer: melody player with a note table and a tone divisor unit.
// One item is worked on at a time. A load, a tick that does not start a new note,
// a start of an empty song and an unused code go from the transfer through ST_DONE
// to the output register; a start or advance onto a rest goes through ST_READ first,
// as the note table is a synchronous memory read once per new note; a start or
// advance onto a sounding note goes through ST_READ and ST_DIV, where the bit-serial
// divider forms 1193180 / frequency one quotient bit a cycle (21 steps). The next
// item can be taken once its result is presented; the result sits in an output
// register, so the next item is taken while it waits for a transfer. tune_length is
// to be written through its own port only while no item is in flight; the block
// itself does not enforce this. Values above MAX_NOTES act as MAX_NOTES. The note
// table is not cleared after reset: a song plays whatever its slots hold.
module tone_note_sequencer_unit #(
	parameter int unsigned MAX_NOTES = tns_pkg::MAX_NOTES_DEF
) (
	input  logic                        clk,
	input  logic                        arst_n,
	// item channel
	input  logic                        in_valid,
	output logic                        in_ready,
	input  logic [tns_pkg::FUNC_W-1:0]  func,
	input  logic [tns_pkg::SLOT_W-1:0]  entry_index,
	input  logic [tns_pkg::FREQ_W-1:0]  note_freq,
	input  logic [tns_pkg::DUR_W-1:0]   note_duration_ms,
	// result channel
	output logic                        out_valid,
	input  logic                        out_ready,
	output logic                        speaker_on,
	output logic [tns_pkg::DIVR_W-1:0]  pit_divisor,
	output logic                        divisor_loaded,
	output logic                        playing,
	output logic [tns_pkg::POS_W-1:0]   note_position,
	// configuration channel
	input  logic                        cfg_valid,
	output logic                        cfg_ready,
	input  logic [tns_pkg::LEN_W-1:0]   tune_length
);

	localparam int unsigned AW     = (MAX_NOTES > 1) ? $clog2(MAX_NOTES) : 1;
	localparam int unsigned DATA_W = tns_pkg::FREQ_W + tns_pkg::DUR_W;
	localparam int unsigned LEN_MAX = (1 << tns_pkg::LEN_W) - 1;
	localparam logic [tns_pkg::LEN_W-1:0] LEN_LIM =
		(MAX_NOTES > LEN_MAX) ? tns_pkg::LEN_W'(LEN_MAX) : tns_pkg::LEN_W'(MAX_NOTES);
	localparam int unsigned PROD_W = tns_pkg::DUR_W + tns_pkg::RECIP_W;

	tns_pkg::state_t state_q, state_d;

	logic [tns_pkg::LEN_W-1:0]  tune_length_q;
	logic [tns_pkg::POS_W-1:0]  current_note_q;
	logic [tns_pkg::TICK_W-1:0] ticks_left_q;
	logic                       active_q;
	logic                       gate_q;
	logic [tns_pkg::DIVR_W-1:0] tone_divisor_q;
	logic                       loaded_q;

	logic                       out_valid_q;
	logic                       speaker_on_q;
	logic [tns_pkg::DIVR_W-1:0] pit_divisor_q;
	logic                       divisor_loaded_q;
	logic                       playing_q;
	logic [tns_pkg::POS_W-1:0]  note_position_q;

	logic                       in_xfer;
	logic [tns_pkg::LEN_W-1:0]  eff_len;
	logic [tns_pkg::TICK_W-1:0] ticks_dec;
	logic [tns_pkg::POS_W-1:0]  next_note;
	logic                       slot_ok;

	logic                       mem_we;
	logic                       mem_re;
	logic [AW-1:0]              mem_raddr;
	logic [DATA_W-1:0]          mem_rdata;
	logic [tns_pkg::FREQ_W-1:0] rd_freq;
	logic [tns_pkg::DUR_W-1:0]  rd_dur;
	logic [PROD_W-1:0]          dur_prod;

	logic                       div_start;
	logic                       div_done;
	logic [tns_pkg::DIVR_W-1:0] div_quot;
	logic                       out_load;

	assign in_ready  = (state_q == tns_pkg::ST_IDLE);
	assign in_xfer   = in_valid & in_ready;
	assign cfg_ready = 1'b1;

	// song length clamped to the table depth
	assign eff_len   = (tune_length_q > LEN_LIM) ? LEN_LIM : tune_length_q;
	assign ticks_dec = ticks_left_q - ((ticks_left_q != '0) ? 1'b1 : 1'b0);
	assign next_note = current_note_q + 1'b1;
	assign slot_ok   = (32'(entry_index) < MAX_NOTES);

	// table read data split and duration converted to ticks
	assign rd_freq  = mem_rdata[DATA_W-1:tns_pkg::DUR_W];
	assign rd_dur   = mem_rdata[tns_pkg::DUR_W-1:0];
	assign dur_prod = PROD_W'(rd_dur) * PROD_W'(tns_pkg::DIV10_MUL);

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= tns_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// next state and control strobes
	always_comb begin
		state_d   = state_q;
		mem_we    = 1'b0;
		mem_re    = 1'b0;
		mem_raddr = '0;
		div_start = 1'b0;
		out_load  = 1'b0;
		case (state_q)
			tns_pkg::ST_IDLE: begin
				if (in_xfer) begin
					state_d = tns_pkg::ST_DONE;
					case (func)
						tns_pkg::FUNC_LOAD: begin
							mem_we = slot_ok;
						end
						tns_pkg::FUNC_START: begin
							if (eff_len != '0) begin
								mem_re    = 1'b1;
								mem_raddr = '0;
								state_d   = tns_pkg::ST_READ;
							end
						end
						tns_pkg::FUNC_TICK: begin
							if (active_q && ticks_dec == '0 && next_note < eff_len) begin
								mem_re    = 1'b1;
								mem_raddr = AW'(next_note);
								state_d   = tns_pkg::ST_READ;
							end
						end
						default: begin
							state_d = tns_pkg::ST_DONE;
						end
					endcase
				end
			end
			tns_pkg::ST_READ: begin
				if (rd_freq != '0) begin
					div_start = 1'b1;
					state_d   = tns_pkg::ST_DIV;
				end else begin
					state_d = tns_pkg::ST_DONE;
				end
			end
			tns_pkg::ST_DIV: begin
				if (div_done) begin
					state_d = tns_pkg::ST_DONE;
				end
			end
			tns_pkg::ST_DONE: begin
				if (!out_valid_q || out_ready) begin
					out_load = 1'b1;
					state_d  = tns_pkg::ST_IDLE;
				end
			end
			default: begin
				state_d = tns_pkg::ST_IDLE;
			end
		endcase
	end

	// song length register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tune_length_q <= '0;
		end else if (cfg_valid && cfg_ready) begin
			tune_length_q <= tune_length;
		end
	end

	// player state: position, tick count, play and gate flags, divisor
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			current_note_q <= '0;
			ticks_left_q   <= '0;
			active_q       <= 1'b0;
			gate_q         <= 1'b0;
			tone_divisor_q <= '0;
			loaded_q       <= 1'b0;
		end else begin
			case (state_q)
				tns_pkg::ST_IDLE: begin
					if (in_xfer) begin
						loaded_q <= 1'b0;
						case (func)
							tns_pkg::FUNC_START: begin
								current_note_q <= '0;
								active_q       <= (eff_len != '0);
								if (eff_len == '0) begin
									gate_q <= 1'b0;
								end
							end
							tns_pkg::FUNC_TICK: begin
								if (active_q) begin
									ticks_left_q <= ticks_dec;
									if (ticks_dec == '0) begin
										current_note_q <= next_note;
										if (next_note >= eff_len) begin
											active_q <= 1'b0;
											gate_q   <= 1'b0;
										end
									end
								end
							end
							default: begin
								loaded_q <= 1'b0;
							end
						endcase
					end
				end
				tns_pkg::ST_READ: begin
					ticks_left_q <= dur_prod[tns_pkg::DIV10_SHIFT +: tns_pkg::TICK_W];
					if (rd_freq == '0) begin
						gate_q <= 1'b0;
					end
				end
				tns_pkg::ST_DIV: begin
					if (div_done) begin
						tone_divisor_q <= div_quot;
						gate_q         <= 1'b1;
						loaded_q       <= 1'b1;
					end
				end
				default: begin
					loaded_q <= loaded_q;
				end
			endcase
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			speaker_on_q     <= gate_q;
			pit_divisor_q    <= tone_divisor_q;
			divisor_loaded_q <= loaded_q;
			playing_q        <= active_q;
			note_position_q  <= current_note_q;
		end
	end

	assign out_valid      = out_valid_q;
	assign speaker_on     = speaker_on_q;
	assign pit_divisor    = pit_divisor_q;
	assign divisor_loaded = divisor_loaded_q;
	assign playing        = playing_q;
	assign note_position  = note_position_q;

	// note table; only one item is in flight, so reads and writes never overlap
	tns_note_mem #(
		.DEPTH  (MAX_NOTES),
		.AW     (AW),
		.DATA_W (DATA_W)
	) u_mem (
		.clk   (clk),
		.we    (mem_we),
		.waddr (AW'(entry_index)),
		.wdata ({note_freq, note_duration_ms}),
		.re    (mem_re),
		.raddr (mem_raddr),
		.rdata (mem_rdata)
	);

	// tone divisor unit
	tns_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.divisor  (rd_freq),
		.done     (div_done),
		.quotient (div_quot)
	);

endmodule

// ===== rtl/tns_checker.sv =====
// port checker for the tone note sequencer and its bind
module tns_checker (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        in_valid,
	input  logic                        in_ready,
	input  logic                        out_valid,
	input  logic                        out_ready,
	input  logic                        speaker_on,
	input  logic [tns_pkg::DIVR_W-1:0]  pit_divisor,
	input  logic                        divisor_loaded,
	input  logic                        playing,
	input  logic [tns_pkg::POS_W-1:0]   note_position
);

	// a waiting result holds its divisor, position and play flag until its transfer
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(pit_divisor)
			&& $stable(note_position) && $stable(playing))
		else $error("result changed while stalled");

	// one item at a time: after an input transfer the block is busy
	a_one_item: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("second item taken while one is in flight");

	// a new divisor always sounds the speaker
	a_loaded_gate: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && divisor_loaded |-> speaker_on && playing)
		else $error("divisor loaded without speaker gate");

	// speaker stays gated off while no song plays
	a_idle_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !playing |-> !speaker_on)
		else $error("speaker on with no song playing");

endmodule

bind tone_note_sequencer_unit tns_checker u_tns_checker (.*);

// ===== tb/tb.sv =====
// testbench of the tone note sequencer: self-checking stimulus with an in-line player model
`timescale 1ns / 1ps

module tb;

	localparam int unsigned NOTE_SLOTS   = 64;
	localparam int unsigned TIMER_CLK_HZ = 1193180;
	localparam int unsigned TICK_MS      = 10;
	localparam int unsigned CYCLE_LIMIT  = 400000;
	localparam int unsigned DRAIN_CYCLES = 40;
	// the one code that the block must ignore
	localparam logic [tns_pkg::FUNC_W-1:0] FUNC_NONE = 2'd3;

	typedef struct packed {
		logic                       speaker_on;
		logic [tns_pkg::DIVR_W-1:0] pit_divisor;
		logic                       divisor_loaded;
		logic                       playing;
		logic [tns_pkg::POS_W-1:0]  note_position;
	} player_report_t;

	logic clk;
	logic arst_n;
	logic in_valid;
	logic in_ready;
	logic [tns_pkg::FUNC_W-1:0] func;
	logic [tns_pkg::SLOT_W-1:0] entry_index;
	logic [tns_pkg::FREQ_W-1:0] note_freq;
	logic [tns_pkg::DUR_W-1:0] note_duration_ms;
	logic out_valid;
	logic out_ready;
	logic speaker_on;
	logic [tns_pkg::DIVR_W-1:0] pit_divisor;
	logic divisor_loaded;
	logic playing;
	logic [tns_pkg::POS_W-1:0] note_position;
	logic cfg_valid;
	logic cfg_ready;
	logic [tns_pkg::LEN_W-1:0] tune_length;

	// player model state
	logic [tns_pkg::FREQ_W-1:0] freq_mem [NOTE_SLOTS];
	logic [tns_pkg::DUR_W-1:0] dur_mem [NOTE_SLOTS];
	bit slot_loaded [NOTE_SLOTS];
	logic [tns_pkg::POS_W-1:0] cur_note;
	logic [tns_pkg::TICK_W-1:0] ticks_rem;
	logic song_active;
	logic gate_on;
	logic [tns_pkg::DIVR_W-1:0] tone_div;
	logic [tns_pkg::LEN_W-1:0] len_setting;

	player_report_t exp_reports [$];
	player_report_t want;
	int unsigned error_count;
	int unsigned cycle_count;
	int unsigned item_gap_pct;
	int unsigned result_stall_pct;
	int unsigned hold_off_left;

	tone_note_sequencer_unit dut (
		.clk              (clk),
		.arst_n           (arst_n),
		.in_valid         (in_valid),
		.in_ready         (in_ready),
		.func             (func),
		.entry_index      (entry_index),
		.note_freq        (note_freq),
		.note_duration_ms (note_duration_ms),
		.out_valid        (out_valid),
		.out_ready        (out_ready),
		.speaker_on       (speaker_on),
		.pit_divisor      (pit_divisor),
		.divisor_loaded   (divisor_loaded),
		.playing          (playing),
		.note_position    (note_position),
		.cfg_valid        (cfg_valid),
		.cfg_ready        (cfg_ready),
		.tune_length      (tune_length)
	);

	// clock
	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	// song length as the block sees it
	function automatic int unsigned eff_length();
		return (len_setting > NOTE_SLOTS) ? NOTE_SLOTS : int'(len_setting);
	endfunction

	// start note idx; returns 1 when a new divisor is programmed
	function automatic bit open_note(input int unsigned idx);
		ticks_rem = tns_pkg::TICK_W'(dur_mem[idx] / TICK_MS);
		if (freq_mem[idx] == '0) begin
			gate_on = 1'b0;
			return 1'b0;
		end
		tone_div = tns_pkg::DIVR_W'(TIMER_CLK_HZ / freq_mem[idx]);
		gate_on = 1'b1;
		return 1'b1;
	endfunction

	// player model: apply one item and return the report it gives
	function automatic player_report_t play_step(input logic [tns_pkg::FUNC_W-1:0] f,
			input logic [tns_pkg::SLOT_W-1:0] s, input logic [tns_pkg::FREQ_W-1:0] fr,
			input logic [tns_pkg::DUR_W-1:0] d);
		player_report_t r;
		bit loaded;
		loaded = 1'b0;
		case (f)
			tns_pkg::FUNC_LOAD: begin
				freq_mem[s] = fr;
				dur_mem[s] = d;
				slot_loaded[s] = 1'b1;
			end
			tns_pkg::FUNC_START: begin
				cur_note = '0;
				if (eff_length() > 0) begin
					song_active = 1'b1;
					loaded = open_note(0);
				end else begin
					song_active = 1'b0;
					gate_on = 1'b0;
				end
			end
			tns_pkg::FUNC_TICK: begin
				if (song_active) begin
					if (ticks_rem > 0)
						ticks_rem = ticks_rem - 1'b1;
					if (ticks_rem == 0) begin
						cur_note = cur_note + 1'b1;
						if (cur_note >= eff_length()) begin
							song_active = 1'b0;
							gate_on = 1'b0;
						end else begin
							loaded = open_note(cur_note);
						end
					end
				end
			end
			default: ;
		endcase
		r.speaker_on = gate_on;
		r.pit_divisor = tone_div;
		r.divisor_loaded = loaded;
		r.playing = song_active;
		r.note_position = cur_note;
		return r;
	endfunction

	// slot that an item would open as a new note, if any
	function automatic bit note_read_ahead(input logic [tns_pkg::FUNC_W-1:0] f,
			output int unsigned slot);
		slot = 0;
		if (f == tns_pkg::FUNC_START)
			return eff_length() > 0;
		if (f == tns_pkg::FUNC_TICK && song_active && ticks_rem <= 1
				&& cur_note + 1 < eff_length()) begin
			slot = cur_note + 1;
			return 1'b1;
		end
		return 1'b0;
	endfunction

	// rests, low tones whose divisor wraps, and the full range
	function automatic logic [tns_pkg::FREQ_W-1:0] pick_freq();
		int unsigned k;
		k = $urandom_range(9);
		if (k < 2)
			return '0;
		if (k == 2)
			return tns_pkg::FREQ_W'($urandom_range(1, 18));
		return tns_pkg::FREQ_W'($urandom_range(0, 32767));
	endfunction

	// mostly short notes, a few of full range
	function automatic logic [tns_pkg::DUR_W-1:0] pick_duration();
		int unsigned k;
		k = $urandom_range(99);
		if (k < 3)
			return tns_pkg::DUR_W'($urandom_range(0, 65535));
		if (k < 15)
			return tns_pkg::DUR_W'($urandom_range(0, 9));
		return tns_pkg::DUR_W'($urandom_range(10, 59));
	endfunction

	// one item transfer, with a random gap in front; ends at the accepting edge
	task automatic send_note_item(input logic [tns_pkg::FUNC_W-1:0] f,
			input logic [tns_pkg::SLOT_W-1:0] s, input logic [tns_pkg::FREQ_W-1:0] fr,
			input logic [tns_pkg::DUR_W-1:0] d);
		@(negedge clk);
		while ($urandom_range(99) < item_gap_pct) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		in_valid <= 1'b1;
		func <= f;
		entry_index <= s;
		note_freq <= fr;
		note_duration_ms <= d;
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
		exp_reports.push_back(play_step(f, s, fr, d));
	endtask

	// send an item, loading any slot it would open that was never written
	task automatic play_item(input logic [tns_pkg::FUNC_W-1:0] f,
			input logic [tns_pkg::SLOT_W-1:0] s, input logic [tns_pkg::FREQ_W-1:0] fr,
			input logic [tns_pkg::DUR_W-1:0] d);
		int unsigned slot;
		if (note_read_ahead(f, slot) && !slot_loaded[slot])
			send_note_item(tns_pkg::FUNC_LOAD, tns_pkg::SLOT_W'(slot), pick_freq(),
				pick_duration());
		send_note_item(f, s, fr, d);
	endtask

	// stop offering items and wait until every expected report has come
	task automatic drain_reports();
		@(negedge clk);
		in_valid <= 1'b0;
		while (exp_reports.size() != 0)
			@(posedge clk);
	endtask

	// song length register transfer
	task automatic write_length(input logic [tns_pkg::LEN_W-1:0] v);
		@(negedge clk);
		cfg_valid <= 1'b1;
		tune_length <= v;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		len_setting = v;
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	// extremes, special cases and a short song traced by hand
	task automatic test_directed();
		write_length('0);
		play_item(FUNC_NONE, '1, '1, '1);
		play_item(tns_pkg::FUNC_START, '0, '0, '0);
		play_item(tns_pkg::FUNC_TICK, '1, '1, '1);
		play_item(tns_pkg::FUNC_LOAD, 6'd63, 15'h7fff, 16'hffff);
		play_item(tns_pkg::FUNC_LOAD, 6'd0, 15'd1, 16'd0);
		play_item(tns_pkg::FUNC_LOAD, 6'd1, 15'd0, 16'd25);
		play_item(tns_pkg::FUNC_LOAD, 6'd2, 15'h7fff, 16'd19);
		play_item(tns_pkg::FUNC_LOAD, 6'd63, 15'd440, 16'd30);
		drain_reports();
		write_length(7'd3);
		play_item(tns_pkg::FUNC_START, '0, '0, '0);
		repeat (5)
			play_item(tns_pkg::FUNC_TICK, '0, '0, '0);
		// restart the song, then shrink it while it plays
		play_item(tns_pkg::FUNC_START, '0, '0, '0);
		drain_reports();
		write_length(7'd1);
		play_item(tns_pkg::FUNC_TICK, '0, '0, '0);
		play_item(FUNC_NONE, '0, '0, '0);
		drain_reports();
	endtask

	// random songs under each idling pattern, with live length changes
	task automatic test_random_play();
		int unsigned k;
		int unsigned eff;
		logic [tns_pkg::SLOT_W-1:0] s;
		logic [tns_pkg::LEN_W-1:0] phase_len [4];
		phase_len = '{7'd2, 7'd64, 7'd127, 7'd5};
		for (int p = 0; p < 4; p++) begin
			drain_reports();
			case (p)
				0: begin item_gap_pct = 0; result_stall_pct = 0; end
				1: begin item_gap_pct = 86; result_stall_pct = 0; end
				2: begin item_gap_pct = 0; result_stall_pct = 86; end
				default: begin item_gap_pct = 30; result_stall_pct = 30; end
			endcase
			write_length(phase_len[p]);
			for (int n = 0; n < 125; n++) begin
				if (n % 40 == 39) begin
					drain_reports();
					if ($urandom_range(3) == 0)
						write_length(tns_pkg::LEN_W'($urandom_range(1, 4)));
					else
						write_length(tns_pkg::LEN_W'($urandom_range(0, 127)));
				end
				k = $urandom_range(99);
				eff = eff_length();
				if (k < 25) begin
					if (eff > 0 && $urandom_range(3) != 0)
						s = tns_pkg::SLOT_W'($urandom_range(0, eff - 1));
					else
						s = tns_pkg::SLOT_W'($urandom_range(0, 63));
					play_item(tns_pkg::FUNC_LOAD, s, pick_freq(), pick_duration());
				end else if (k < 31) begin
					play_item(tns_pkg::FUNC_START, tns_pkg::SLOT_W'($urandom),
						tns_pkg::FREQ_W'($urandom), tns_pkg::DUR_W'($urandom));
				end else if (k < 35) begin
					play_item(FUNC_NONE, tns_pkg::SLOT_W'($urandom),
						tns_pkg::FREQ_W'($urandom), tns_pkg::DUR_W'($urandom));
				end else begin
					play_item(tns_pkg::FUNC_TICK, tns_pkg::SLOT_W'($urandom),
						tns_pkg::FREQ_W'($urandom), tns_pkg::DUR_W'($urandom));
				end
			end
		end
		drain_reports();
	endtask

	// long receiver hold-off so the result register fills and the input stalls
	task automatic test_backpressure();
		drain_reports();
		item_gap_pct = 0;
		result_stall_pct = 0;
		write_length(7'd4);
		for (int i = 0; i < 4; i++)
			play_item(tns_pkg::FUNC_LOAD, tns_pkg::SLOT_W'(i), pick_freq(),
				tns_pkg::DUR_W'($urandom_range(0, 35)));
		drain_reports();
		hold_off_left = 300;
		play_item(tns_pkg::FUNC_START, '0, '0, '0);
		repeat (24)
			play_item(tns_pkg::FUNC_TICK, '0, '0, '0);
		drain_reports();
	endtask

	// result side ready, with random stalls and the long hold-off
	initial begin
		out_ready = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_off_left > 0) begin
				out_ready <= 1'b0;
				hold_off_left = hold_off_left - 1;
			end else begin
				out_ready <= ($urandom_range(99) >= result_stall_pct);
			end
		end
	end

	// compare each result transfer with the oldest expectation
	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready) begin
			if (exp_reports.size() == 0) begin
				$error("result transfer with no expectation waiting");
				error_count++;
			end else begin
				want = exp_reports.pop_front();
				if (speaker_on !== want.speaker_on) begin
					$error("speaker_on: expected %0d, got %0d", want.speaker_on, speaker_on);
					error_count++;
				end
				if (pit_divisor !== want.pit_divisor) begin
					$error("pit_divisor: expected %0d, got %0d", want.pit_divisor, pit_divisor);
					error_count++;
				end
				if (divisor_loaded !== want.divisor_loaded) begin
					$error("divisor_loaded: expected %0d, got %0d", want.divisor_loaded,
						divisor_loaded);
					error_count++;
				end
				if (playing !== want.playing) begin
					$error("playing: expected %0d, got %0d", want.playing, playing);
					error_count++;
				end
				if (note_position !== want.note_position) begin
					$error("note_position: expected %0d, got %0d", want.note_position,
						note_position);
					error_count++;
				end
			end
		end
	end

	// watchdog
	initial begin
		cycle_count = 0;
		while (cycle_count < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("Verification failed");
		$finish;
	end

	// reset, then the tests in turn
	initial begin
		arst_n = 1'b0;
		in_valid = 1'b0;
		func = tns_pkg::FUNC_LOAD;
		entry_index = '0;
		note_freq = '0;
		note_duration_ms = '0;
		cfg_valid = 1'b0;
		tune_length = '0;
		error_count = 0;
		item_gap_pct = 0;
		result_stall_pct = 0;
		hold_off_left = 0;
		cur_note = '0;
		ticks_rem = '0;
		song_active = 1'b0;
		gate_on = 1'b0;
		tone_div = '0;
		len_setting = '0;
		for (int i = 0; i < NOTE_SLOTS; i++) begin
			freq_mem[i] = '0;
			dur_mem[i] = '0;
			slot_loaded[i] = 1'b0;
		end
		repeat (11)
			@(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		test_directed();
		test_random_play();
		test_backpressure();

		drain_reports();
		repeat (DRAIN_CYCLES)
			@(posedge clk);
		if (exp_reports.size() != 0) begin
			$error("%0d expected results never arrived", exp_reports.size());
			error_count++;
		end
		if (error_count == 0)
			$display("Verification passed");
		else
			$display("Verification failed");
		$finish;
	end

endmodule
